// ----- hw/rtl/cps_pkg.sv -----
package cps_pkg;

  // defaults for the top level parameters
  localparam int MAX_WIDTH_DEF    = 128;
  localparam int MAX_HEIGHT_DEF   = 128;
  localparam int MAX_CHANNELS_DEF = 4;

  // radius saturates here; the sequencer counters are sized for it
  localparam int MAX_RADIUS = 4;

  // fixed field widths
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 32;
  localparam int INDEX_W    = 14;
  localparam int DIM_W      = 8;
  localparam int COL_W      = 9;
  localparam int RAD_W      = 3;
  localparam int NCH_W      = 3;
  localparam int CTR_W      = 3;
  localparam int SPAN_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // command queue between front and back, power of two
  localparam int IN_DEPTH  = 2;
  localparam int IN_PTR_W  = $clog2(IN_DEPTH);
  localparam int IN_LVL_W  = $clog2(IN_DEPTH) + 1;

  // result queue, power of two
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_LVL_W = $clog2(OUT_DEPTH) + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 3'd0,
    CFG_STEP     = 3'd1,
    CFG_WIDTH    = 3'd2,
    CFG_HEIGHT   = 3'd3,
    CFG_CHANNELS = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                        kind;
    logic                             in_store;
    logic [INDEX_W-1:0]               index;
    logic [NUM_CH-1:0][CH_W-1:0]      ch;
  } cmd_t;

  // configuration after saturation to legal ranges
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [RAD_W-1:0] radius;
    logic [DIM_W-1:0] step;
    logic [NCH_W-1:0] channels;
  } eff_cfg_t;

  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] ch;
    logic                        last;
  } pix_t;

endpackage

// ----- hw/rtl/clamped_patch_scanner_unit.sv -----
// clamped patch scanner: holds one frame of up to MAX_WIDTH x MAX_HEIGHT pixels, each
// of up to four raw 32-bit channels, and streams square patches out of it. a load
// transaction (in_kind = 0) writes one pixel at in_pixel_index; a request transaction
// (in_kind = 1) first wraps the scan position to the next row when the column has run
// past the width, then emits a patch of side 2*radius-1 centred on it, row-major, with
// coordinates clamped to the frame edges and out_last_in_patch set on the final pixel,
// and finally moves the column on by scan_step. a load occupies the back end only while
// its command is taken; a request occupies it while it takes the command, streams the
// patch and clears its coordinate and address stages. the single read port of the frame
// store delivers one pixel per cycle while the result queue has a slot for it. a
// two-entry command queue lets new transactions be taken while a patch is streaming,
// and an eight-entry result queue lets the consumer stall without losing pixels. the
// frame store is not cleared: reading a pixel that was never loaded gives arbitrary
// data. configuration should only be written while the block is idle.
module clamped_patch_scanner_unit #(
  parameter int MAX_WIDTH    = cps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = cps_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_CHANNELS = cps_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  // input transactions
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_kind,
  input  logic [cps_pkg::INDEX_W-1:0]       in_pixel_index,
  input  logic [cps_pkg::CH_W-1:0]          in_ch0,
  input  logic [cps_pkg::CH_W-1:0]          in_ch1,
  input  logic [cps_pkg::CH_W-1:0]          in_ch2,
  input  logic [cps_pkg::CH_W-1:0]          in_ch3,

  // result transactions
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [cps_pkg::CH_W-1:0]          out_ch0,
  output logic [cps_pkg::CH_W-1:0]          out_ch1,
  output logic [cps_pkg::CH_W-1:0]          out_ch2,
  output logic [cps_pkg::CH_W-1:0]          out_ch3,
  output logic                              out_last_in_patch,

  // configuration writes
  input  logic                              cfg_we,
  input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // raw configuration registers, as written
  logic [cps_pkg::RAD_W-1:0]   cfg_radius_r;
  logic [cps_pkg::DIM_W-1:0]   cfg_step_r;
  logic [cps_pkg::DIM_W-1:0]   cfg_width_r;
  logic [cps_pkg::DIM_W-1:0]   cfg_height_r;
  logic [cps_pkg::NCH_W-1:0]   cfg_channels_r;

  cps_pkg::eff_cfg_t           eff_cfg;
  cps_pkg::cmd_t               cmd;
  logic                        cmd_valid;
  logic                        cmd_pop;
  logic                        res_push;
  cps_pkg::pix_t               res_data;
  cps_pkg::pix_t               res_head;
  logic [cps_pkg::OUT_LVL_W-1:0] res_level;
  logic [cps_pkg::NUM_CH-1:0][cps_pkg::CH_W-1:0] in_ch;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radius_r   <= cps_pkg::RAD_W'(1);
      cfg_step_r     <= cps_pkg::DIM_W'(1);
      cfg_width_r    <= cps_pkg::DIM_W'(128);
      cfg_height_r   <= cps_pkg::DIM_W'(128);
      cfg_channels_r <= cps_pkg::NCH_W'(4);
    end else if (cfg_we) begin
      unique case (cps_pkg::cfg_idx_t'(cfg_index))
        cps_pkg::CFG_RADIUS:   cfg_radius_r   <= cfg_data[cps_pkg::RAD_W-1:0];
        cps_pkg::CFG_STEP:     cfg_step_r     <= cfg_data;
        cps_pkg::CFG_WIDTH:    cfg_width_r    <= cfg_data;
        cps_pkg::CFG_HEIGHT:   cfg_height_r   <= cfg_data;
        cps_pkg::CFG_CHANNELS: cfg_channels_r <= cfg_data[cps_pkg::NCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // saturate every setting into its legal range; zero counts as one
  always_comb begin
    if (cfg_width_r == '0) begin
      eff_cfg.width = cps_pkg::DIM_W'(1);
    end else if (cfg_width_r > MAX_WIDTH) begin
      eff_cfg.width = cps_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      eff_cfg.width = cfg_width_r;
    end

    if (cfg_height_r == '0) begin
      eff_cfg.height = cps_pkg::DIM_W'(1);
    end else if (cfg_height_r > MAX_HEIGHT) begin
      eff_cfg.height = cps_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      eff_cfg.height = cfg_height_r;
    end

    if (cfg_radius_r == '0) begin
      eff_cfg.radius = cps_pkg::RAD_W'(1);
    end else if (cfg_radius_r > cps_pkg::MAX_RADIUS) begin
      eff_cfg.radius = cps_pkg::RAD_W'(cps_pkg::MAX_RADIUS);
    end else begin
      eff_cfg.radius = cfg_radius_r;
    end

    if (cfg_channels_r == '0) begin
      eff_cfg.channels = cps_pkg::NCH_W'(1);
    end else if (cfg_channels_r > MAX_CHANNELS) begin
      eff_cfg.channels = cps_pkg::NCH_W'(MAX_CHANNELS);
    end else begin
      eff_cfg.channels = cfg_channels_r;
    end

    eff_cfg.step = (cfg_step_r == '0) ? cps_pkg::DIM_W'(1) : cfg_step_r;
  end

  assign in_ch = {in_ch3, in_ch2, in_ch1, in_ch0};

  // front: takes transactions, classifies them, queues them
  cps_front #(
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .kind        (in_kind),
    .pixel_index (in_pixel_index),
    .ch          (in_ch),
    .deq_valid   (cmd_valid),
    .deq_cmd     (cmd),
    .deq_pop     (cmd_pop)
  );

  // back: frame store, scan position and patch sequencer
  cps_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (eff_cfg),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .fifo_level (res_level),
    .push       (res_push),
    .push_data  (res_data)
  );

  // result queue toward the consumer
  cps_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (res_head),
    .level     (res_level)
  );

  assign out_ch0           = res_head.ch[0];
  assign out_ch1           = res_head.ch[1];
  assign out_ch2           = res_head.ch[2];
  assign out_ch3           = res_head.ch[3];
  assign out_last_in_patch = res_head.last;

endmodule

// ----- hw/rtl/cps_front.sv -----
module cps_front #(
  parameter int DEPTH = cps_pkg::MAX_WIDTH_DEF * cps_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          push,
  output logic                                          full,
  input  logic                                          kind,
  input  logic [cps_pkg::INDEX_W-1:0]                   pixel_index,
  input  logic [cps_pkg::NUM_CH-1:0][cps_pkg::CH_W-1:0] ch,
  output logic                                          deq_valid,
  output cps_pkg::cmd_t                                 deq_cmd,
  input  logic                                          deq_pop
);

  cps_pkg::cmd_t                      q_r [cps_pkg::IN_DEPTH];
  cps_pkg::cmd_t                      cmd_in;
  logic [cps_pkg::IN_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [cps_pkg::IN_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [cps_pkg::IN_LVL_W-1:0]       count_r, count_nxt;
  logic                               accept;

  // classify the transaction on the way in
  always_comb begin
    cmd_in.kind     = cps_pkg::cmd_kind_t'(kind);
    cmd_in.in_store = (pixel_index < DEPTH);
    cmd_in.index    = pixel_index;
    cmd_in.ch       = ch;
  end

  assign full      = (count_r == cps_pkg::IN_LVL_W'(cps_pkg::IN_DEPTH));
  assign accept    = push && !full;
  assign deq_valid = (count_r != '0);
  assign deq_cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = deq_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + cps_pkg::IN_LVL_W'(accept) - cps_pkg::IN_LVL_W'(deq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- hw/rtl/cps_out_fifo.sv -----
module cps_out_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  cps_pkg::pix_t                   push_data,
  input  logic                            pop,
  output logic                            empty,
  output cps_pkg::pix_t                   head,
  output logic [cps_pkg::OUT_LVL_W-1:0]   level
);

  cps_pkg::pix_t                      q_r [cps_pkg::OUT_DEPTH];
  logic [cps_pkg::OUT_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cps_pkg::OUT_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cps_pkg::OUT_LVL_W-1:0]      level_r, level_nxt;
  logic                               take;

  assign empty = (level_r == '0);
  assign take  = pop && !empty;
  assign head  = q_r[rd_ptr_r];
  assign level = level_r;

  // the back end only pushes when it holds a credit
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = take ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r + cps_pkg::OUT_LVL_W'(push) - cps_pkg::OUT_LVL_W'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/cps_back.sv -----
module cps_back #(
  parameter int MAX_WIDTH    = cps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = cps_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_CHANNELS = cps_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cps_pkg::eff_cfg_t               cfg,
  input  logic                            cmd_valid,
  input  cps_pkg::cmd_t                   cmd,
  output logic                            cmd_pop,
  input  logic [cps_pkg::OUT_LVL_W-1:0]   fifo_level,
  output logic                            push,
  output cps_pkg::pix_t                   push_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PX_W   = cps_pkg::DIM_W + 2;
  localparam int PY_W   = ((ROW_W > cps_pkg::DIM_W) ? ROW_W : cps_pkg::DIM_W) + 2;
  localparam int PROD_W = ROW_W + cps_pkg::DIM_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef logic [MAX_CHANNELS-1:0][cps_pkg::CH_W-1:0] word_t;

  // frame store
  word_t                          mem [DEPTH];
  word_t                          rd_data_r;
  logic                           mem_we;

  state_t                         state_r, state_nxt;
  logic [cps_pkg::COL_W-1:0]      scan_col_r, scan_col_nxt;
  logic [ROW_W-1:0]               scan_row_r, scan_row_nxt;
  logic [cps_pkg::DIM_W-1:0]      cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]               cur_row_r, cur_row_nxt;
  logic [cps_pkg::CTR_W-1:0]      dx_r, dx_nxt;
  logic [cps_pkg::CTR_W-1:0]      dy_r, dy_nxt;

  logic                           s1_v_r, s1_v_nxt;
  logic                           s1_last_r, s1_last_nxt;
  logic [cps_pkg::DIM_W-1:0]      s1_px_r, s1_px_nxt;
  logic [ROW_W-1:0]               s1_py_r, s1_py_nxt;
  logic                           s2_v_r;
  logic                           s2_last_r;
  logic [ADDR_W-1:0]              addr_r, addr_nxt;
  logic                           s3_v_r;
  logic                           s3_last_r;

  logic [cps_pkg::DIM_W-1:0]      w_m1, h_m1;
  logic [cps_pkg::SPAN_W-1:0]     span;
  logic [cps_pkg::CTR_W-1:0]      side_m1;
  logic                           col_wrap;
  logic [ROW_W:0]                 row_inc;
  logic [cps_pkg::COL_W-1:0]      start_col;
  logic [ROW_W-1:0]               start_row;
  logic [cps_pkg::OUT_LVL_W:0]    used;
  logic                           credit;
  logic                           is_last;
  logic signed [PX_W-1:0]         px_s, px_hi;
  logic signed [PY_W-1:0]         py_s, py_hi;
  logic [cps_pkg::DIM_W-1:0]      px;
  logic [ROW_W-1:0]               py;
  logic [PROD_W-1:0]              prod;
  logic [PROD_W:0]                lin;
  logic [cps_pkg::NUM_CH-1:0][cps_pkg::CH_W-1:0] rd_full;
  logic [cps_pkg::NUM_CH-1:0][cps_pkg::CH_W-1:0] out_ch;

  assign w_m1    = cfg.width - 1'b1;
  assign h_m1    = cfg.height - 1'b1;
  assign span    = cps_pkg::SPAN_W'(cfg.radius - 1'b1);
  assign side_m1 = cps_pkg::CTR_W'((cfg.radius - 3'd1) << 1);

  // scan position wrap on a request
  always_comb begin
    col_wrap = (scan_col_r >= cfg.width);
    row_inc  = {1'b0, scan_row_r} + 1'b1;
    if (col_wrap) begin
      start_col = '0;
      start_row = (row_inc >= cfg.height) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      start_col = scan_col_r;
      start_row = scan_row_r;
    end
  end

  // loads and requests wait until no read is left in the address stages
  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid && !s1_v_r && !s2_v_r;
  assign mem_we  = cmd_pop && (cmd.kind == cps_pkg::CMD_LOAD) && cmd.in_store;

  // a read is issued only if its result has a slot in the result queue
  assign used   = (cps_pkg::OUT_LVL_W + 1)'(fifo_level) + (cps_pkg::OUT_LVL_W + 1)'(s1_v_r)
                + (cps_pkg::OUT_LVL_W + 1)'(s2_v_r) + (cps_pkg::OUT_LVL_W + 1)'(s3_v_r);
  assign credit = (used < cps_pkg::OUT_DEPTH);

  // clamped patch coordinates
  always_comb begin
    px_s  = signed'(PX_W'(cur_col_r)) + signed'(PX_W'(dx_r)) - signed'(PX_W'(span));
    px_hi = signed'(PX_W'(w_m1));
    py_s  = signed'(PY_W'(cur_row_r)) + signed'(PY_W'(dy_r)) - signed'(PY_W'(span));
    py_hi = signed'(PY_W'(h_m1));
    if (px_s < 0) begin
      px = '0;
    end else if (px_s > px_hi) begin
      px = w_m1;
    end else begin
      px = cps_pkg::DIM_W'(px_s);
    end
    if (py_s < 0) begin
      py = '0;
    end else if (py_s > py_hi) begin
      py = ROW_W'(h_m1);
    end else begin
      py = ROW_W'(py_s);
    end
  end

  assign is_last = (dx_r == side_m1) && (dy_r == side_m1);

  // raster address from the registered coordinates
  assign prod     = s1_py_r * cfg.width;
  assign lin      = {1'b0, prod} + (PROD_W + 1)'(s1_px_r);
  assign addr_nxt = ADDR_W'(lin);

  always_comb begin
    state_nxt    = state_r;
    scan_col_nxt = scan_col_r;
    scan_row_nxt = scan_row_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    s1_v_nxt     = 1'b0;
    s1_last_nxt  = s1_last_r;
    s1_px_nxt    = s1_px_r;
    s1_py_nxt    = s1_py_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop && (cmd.kind == cps_pkg::CMD_REQUEST)) begin
          cur_col_nxt  = cps_pkg::DIM_W'(start_col);
          cur_row_nxt  = start_row;
          scan_row_nxt = start_row;
          scan_col_nxt = start_col + cps_pkg::COL_W'(cfg.step);
          dx_nxt       = '0;
          dy_nxt       = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (credit) begin
          s1_v_nxt    = 1'b1;
          s1_last_nxt = is_last;
          s1_px_nxt   = px;
          s1_py_nxt   = py;
          if (dx_r == side_m1) begin
            dx_nxt = '0;
            dy_nxt = dy_r + 1'b1;
            if (is_last) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            dx_nxt = dx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_col_r <= '0;
      scan_row_r <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_col_r <= scan_col_nxt;
      scan_row_r <= scan_row_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_row_r  <= cur_row_nxt;
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
      s1_v_r     <= s1_v_nxt;
      s1_last_r  <= s1_last_nxt;
      s1_px_r    <= s1_px_nxt;
      s1_py_r    <= s1_py_nxt;
      s2_v_r     <= s1_v_r;
      s2_last_r  <= s1_last_r;
      addr_r     <= addr_nxt;
      s3_v_r     <= s2_v_r;
      s3_last_r  <= s2_last_r;
    end
  end

  // one write port for loads, one registered read port for patches
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ADDR_W'(cmd.index)] <= cmd.ch[MAX_CHANNELS-1:0];
    end
    if (s2_v_r) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // channels past the channel count read as zero
  assign rd_full = (cps_pkg::NUM_CH * cps_pkg::CH_W)'(rd_data_r);

  always_comb begin
    for (int c = 0; c < cps_pkg::NUM_CH; c++) begin
      out_ch[c] = (c < cfg.channels) ? rd_full[c] : '0;
    end
  end

  assign push           = s3_v_r;
  assign push_data.ch   = out_ch;
  assign push_data.last = s3_last_r;

`ifndef SYNTHESIS
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(fifo_level) + $countones({s1_v_r, s2_v_r, s3_v_r})) <= cps_pkg::OUT_DEPTH)
    else $error("result queue oversubscribed");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> ((s1_px_r < cfg.width) && (s1_py_r < cfg.height)))
    else $error("patch coordinate outside the frame");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_last_r) |-> (state_r == ST_IDLE))
    else $error("sequencer still scanning after last pixel");
`endif

endmodule
